// ===== rtl/abeat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the adaptive beat scheduler.
// Depends on nothing; every other file of the block imports it.
package abeat_pkg;

	// Field widths.
	localparam int ASYNCH_W   = 12;
	localparam int MASK_W     = 4;
	localparam int ADJ_W      = 12;
	localparam int TIME_W     = 32;
	localparam int ALPHA_W    = 9;
	localparam int TEMPO_W    = 9;
	localparam int PCOUNT_W   = 3;

	// Number of asynchrony fields carried by one input word.
	localparam int ASYNCH_FIELDS    = 4;
	localparam int PLAYER_SLOTS_DEF = 4;

	// Accumulated sum of up to four asynchronies, and the count of counted players.
	localparam int SUM_W = ASYNCH_W + 2;
	localparam int CNT_W = 3;

	// Shared divider widths: a 16-bit dividend over a 9-bit divisor.
	localparam int DIVIDEND_W = 16;
	localparam int DIVISOR_W  = 9;
	localparam int STEP_W     = $clog2(DIVIDEND_W);

	// Milliseconds in one minute.
	localparam logic [DIVIDEND_W-1:0] MINUTE_MS = 16'd60000;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PCOUNT  = 2'd3;

	// Register values after reset.
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET   = 9'd77;
	localparam logic [TEMPO_W-1:0]  TEMPO_RESET   = 9'd120;
	localparam logic                AVERAGE_RESET = 1'b1;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET  = 3'd4;

	typedef logic signed [ASYNCH_W-1:0] asynch_t;
	typedef logic signed [ADJ_W-1:0]    adj_t;

endpackage

// ===== rtl/abeat_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the adaptive beat scheduler: beat words in and
// adjustment words out. Depends on abeat_pkg for field widths.

interface abeat_in_if;
	import abeat_pkg::*;

	logic              valid;
	logic              ready;
	asynch_t           asynch_0;
	asynch_t           asynch_1;
	asynch_t           asynch_2;
	asynch_t           asynch_3;
	logic [MASK_W-1:0] active_mask;
	logic [MASK_W-1:0] responded_mask;

	modport source (
		output valid, asynch_0, asynch_1, asynch_2, asynch_3, active_mask, responded_mask,
		input  ready
	);
	modport sink (
		input  valid, asynch_0, asynch_1, asynch_2, asynch_3, active_mask, responded_mask,
		output ready
	);
endinterface

interface abeat_out_if;
	import abeat_pkg::*;

	logic              valid;
	logic              ready;
	adj_t              adjustment;
	logic [TIME_W-1:0] next_beat_time;

	modport source (
		output valid, adjustment, next_beat_time,
		input  ready
	);
	modport sink (
		input  valid, adjustment, next_beat_time,
		output ready
	);
endinterface

// ===== rtl/abeat_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on abeat_pkg for operand widths.

module abeat_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [abeat_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [abeat_pkg::DIVISOR_W-1:0]   divisor,
	output logic                              done,
	output logic [abeat_pkg::DIVIDEND_W-1:0]  quotient
);
	import abeat_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    shifted;
	logic                  fits;
	logic [DIVISOR_W:0]    diff;
	logic [DIVISOR_W-1:0]  rem_next;
	logic                  last_step;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		shifted  = {rem_q, quo_q[DIVIDEND_W-1]};
		fits     = (shifted >= {1'b0, divisor_q});
		diff     = shifted - {1'b0, divisor_q};
		rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
	end

	assign last_step = ~start & busy_q & (step_q == STEP_W'(DIVIDEND_W - 1));

	// Control: load on start, then one step a cycle until the last bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the quotient bits shift in where the dividend bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/adaptive_beat_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the adaptive beat scheduler: configuration registers, beat
// sequencer and datapath. Depends on abeat_pkg, abeat_if and abeat_div.

// One beat word is taken when the block is idle; its result word appears in the
// output register in the same cycle as the block returns to idle, so the next
// beat word can be taken while that result is presented. A beat first adds up
// the counted players' asynchronies one slot at a time, then makes two passes
// through the shared 16-step divider (first the beat interval from the tempo,
// then the mean asynchrony), scales the mean by alpha and updates the beat
// time. With averaging off or no counted player the second division and the
// scaling are skipped and the adjustment is zero. The next beat word is taken
// while the last result still waits in the output register; a beat that finds
// that register still full waits in its update step. Configuration is written
// through a plain write port; the user must write it only while the block is
// idle, which the block itself does not enforce.
module adaptive_beat_scheduler #(
	parameter int PLAYER_SLOTS = abeat_pkg::PLAYER_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [abeat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abeat_pkg::CFG_DATA_W-1:0] cfg_data,
	abeat_in_if.sink                         beat_in,
	abeat_out_if.source                      beat_out
);
	import abeat_pkg::*;

	// Slots that may count: bounded by the parameter and by the fields present.
	localparam int SLOT_LIMIT = (PLAYER_SLOTS < ASYNCH_FIELDS) ? PLAYER_SLOTS : ASYNCH_FIELDS;
	localparam int IDX_W      = $clog2(ASYNCH_FIELDS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACCUM,
		S_DIV_INT,
		S_DIV_MEAN,
		S_SCALE,
		S_UPDATE
	} state_t;

	state_t                  state_q;

	// Configuration registers.
	logic [ALPHA_W-1:0]      alpha_q;
	logic [TEMPO_W-1:0]      tempo_q;
	logic                    average_q;
	logic [PCOUNT_W-1:0]     pcount_q;

	// Beat word and working registers.
	asynch_t                 asynch_q [ASYNCH_FIELDS];
	logic [ASYNCH_FIELDS-1:0] count_mask_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIVIDEND_W-1:0]   interval_q;
	adj_t                    mean_q;
	adj_t                    adj_q;
	logic [TIME_W-1:0]       beat_time_q;
	logic                    div_start_q;

	// Output register.
	logic                    out_valid_q;
	adj_t                    out_adj_q;
	logic [TIME_W-1:0]       out_time_q;

	logic [PCOUNT_W-1:0]     slots;
	logic [ASYNCH_FIELDS-1:0] count_mask;
	logic                    in_fire;
	logic                    out_free;
	logic                    div_start_next;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0]        sum_mag;
	logic [DIVIDEND_W-1:0]   div_dividend;
	logic [DIVISOR_W-1:0]    div_divisor;
	logic                    div_done;
	logic [DIVIDEND_W-1:0]   div_quotient;
	adj_t                    quo_low;
	adj_t                    mean_next;
	logic signed [21:0]      prod;
	logic signed [13:0]      scaled;
	adj_t                    scaled_sat;
	logic [TIME_W-1:0]       time_next;

	// Slots considered this beat and the players that count within them.
	always_comb begin
		slots = (pcount_q > PCOUNT_W'(SLOT_LIMIT)) ? PCOUNT_W'(SLOT_LIMIT) : pcount_q;
		for (int i = 0; i < ASYNCH_FIELDS; i++) begin
			count_mask[i] = beat_in.active_mask[i] & beat_in.responded_mask[i] &
				(PCOUNT_W'(i) < slots);
		end
	end

	assign in_fire  = beat_in.valid & beat_in.ready;
	assign out_free = ~out_valid_q | beat_out.ready;

	// A division starts after the last slot is summed, and again for the mean
	// when averaging is on and some player counted.
	assign div_start_next =
		((state_q == S_ACCUM) && (idx_q == IDX_W'(ASYNCH_FIELDS - 1))) ||
		((state_q == S_DIV_INT) && div_done && average_q && (cnt_q != '0));

	// Running sum of the counted asynchronies, one slot a cycle.
	always_comb begin
		sum_next = sum_q;
		if (count_mask_q[idx_q]) begin
			sum_next = sum_q + SUM_W'(asynch_q[idx_q]);
		end
		sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	end

	// Divider operands follow the division under way.
	always_comb begin
		if (state_q == S_DIV_MEAN) begin
			div_dividend = DIVIDEND_W'(sum_mag);
			div_divisor  = DIVISOR_W'(cnt_q);
		end else begin
			div_dividend = MINUTE_MS;
			div_divisor  = (tempo_q == '0) ? DIVISOR_W'(1) : tempo_q;
		end
	end

	abeat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Signed mean from the unsigned quotient; the magnitude never exceeds 2048.
	always_comb begin
		quo_low   = div_quotient[ADJ_W-1:0];
		mean_next = sum_q[SUM_W-1] ? (~quo_low + 1'b1) : quo_low;
	end

	// Scale by alpha with floor, then saturate to the adjustment range.
	always_comb begin
		prod   = 22'(mean_q) * $signed({13'b0, alpha_q});
		scaled = prod[21:8];
		if (scaled > 14'sd2047) begin
			scaled_sat = 12'sh7FF;
		end else if (scaled < -14'sd2048) begin
			scaled_sat = 12'sh800;
		end else begin
			scaled_sat = scaled[ADJ_W-1:0];
		end
	end

	assign time_next = beat_time_q + TIME_W'(interval_q) + TIME_W'(adj_q);

	// Sequencer, configuration and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alpha_q     <= ALPHA_RESET;
			tempo_q     <= TEMPO_RESET;
			average_q   <= AVERAGE_RESET;
			pcount_q    <= PCOUNT_RESET;
			beat_time_q <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_adj_q   <= '0;
			out_time_q  <= '0;
		end else begin
			div_start_q <= div_start_next;

			// The output word is loaded by the update step or cleared once taken.
			if ((state_q == S_UPDATE) && out_free) begin
				out_valid_q <= 1'b1;
				out_adj_q   <= adj_q;
				out_time_q  <= time_next;
			end else if (beat_out.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_ALPHA:   alpha_q   <= cfg_data[ALPHA_W-1:0];
					REG_TEMPO:   tempo_q   <= cfg_data[TEMPO_W-1:0];
					REG_AVERAGE: average_q <= cfg_data[0];
					REG_PCOUNT:  pcount_q  <= cfg_data[PCOUNT_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_ACCUM;
					end
				end
				S_ACCUM: begin
					if (idx_q == IDX_W'(ASYNCH_FIELDS - 1)) begin
						state_q <= S_DIV_INT;
					end
				end
				S_DIV_INT: begin
					if (div_done) begin
						if (average_q && cnt_q != '0) begin
							state_q <= S_DIV_MEAN;
						end else begin
							state_q <= S_UPDATE;
						end
					end
				end
				S_DIV_MEAN: begin
					if (div_done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (out_free) begin
						beat_time_q <= time_next;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					asynch_q[0]  <= beat_in.asynch_0;
					asynch_q[1]  <= beat_in.asynch_1;
					asynch_q[2]  <= beat_in.asynch_2;
					asynch_q[3]  <= beat_in.asynch_3;
					count_mask_q <= count_mask;
					idx_q        <= '0;
					sum_q        <= '0;
					cnt_q        <= '0;
				end
			end
			S_ACCUM: begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + CNT_W'(count_mask_q[idx_q]);
				idx_q <= idx_q + 1'b1;
			end
			S_DIV_INT: begin
				if (div_done) begin
					interval_q <= div_quotient;
					adj_q      <= '0;
				end
			end
			S_DIV_MEAN: begin
				if (div_done) begin
					mean_q <= mean_next;
				end
			end
			S_SCALE: begin
				adj_q <= scaled_sat;
			end
			default: ;
		endcase
	end

	assign beat_in.ready           = (state_q == S_IDLE);
	assign beat_out.valid          = out_valid_q;
	assign beat_out.adjustment     = out_adj_q;
	assign beat_out.next_beat_time = out_time_q;

endmodule
